>>> rtl/sfar_pkg.sv
package sfar_pkg;

    localparam int DEF_MAX_NEURONS = 256;
    localparam int DEF_MAX_FANIN   = 16;

    localparam int OP_W     = 3;
    localparam int NEURON_W = 8;
    localparam int SLOT_W   = 4;
    localparam int CNT_W    = 5;
    localparam int ACT_W    = 16;
    localparam int RND_W    = 32;
    localparam int NCNT_W   = 9;
    localparam int STRIDE_W = 5;

    localparam logic [OP_W-1:0] OP_WR_WIRE  = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_COUNT = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_ACT   = 3'd2;
    localparam logic [OP_W-1:0] OP_AVERAGE  = 3'd3;
    localparam logic [OP_W-1:0] OP_REWIRE   = 3'd4;

    localparam logic REG_NEURON_COUNT = 1'b0;
    localparam logic REG_ROW_STRIDE   = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input beat
        logic wr_wire;     // write wiring entry at computed address
        logic wr_count;
        logic wr_act;
        logic rd_count_n;  // read count of item neuron
        logic rd_count_f;  // read count of from feeder
        logic rd_wire;     // issue wiring read at walk/slot address
        logic rd_act;      // issue activation read for fetched id
        logic acc_clr;
        logic acc_add;
        logic div_start;   // start divider
        logic div_sel;     // 0: sum / count, 1: random / count
        logic set_from;    // capture from slot result
        logic set_to;      // capture to slot result
        logic wire_from;   // capture from id
        logic wire_to;     // capture to id
        logic rw_write;    // final rewire write
        logic walk_clr;
        logic walk_inc;
        logic out_load;
    } sfar_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            n_ok;
        logic            slot_ok;
        logic            cnt_zero;
        logic            walk_done;
        logic            div_busy;
        logic            from_ok;
        logic            out_busy;
    } sfar_stat_t;

endpackage

>>> rtl/sfar_div.sv
module sfar_div
    import sfar_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             neg_in,
    input  logic [RND_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             busy,
    output logic [RND_W-1:0] quotient,
    output logic [CNT_W-1:0] remainder
);
    // restoring divider, one quotient bit per cycle
    localparam int CW = $clog2(RND_W + 1);

    logic [RND_W-1:0] q_reg, q_next;
    logic [CNT_W:0]   r_reg, r_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic             busy_reg, busy_next;
    logic [CNT_W:0]   trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        trial = {r_reg[CNT_W-1:0], q_reg[RND_W-1]};
        if (start) begin
            q_next = neg_in ? (~dividend + 1'b1) : dividend;
            r_next = '0;
            cnt_next = CW'(RND_W);
            neg_next = neg_in;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                r_next = trial - {1'b0, divisor};
                q_next = {q_reg[RND_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[RND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = neg_reg ? (~q_reg + 1'b1) : q_reg;
    assign remainder = r_reg[CNT_W-1:0];
endmodule

>>> rtl/sfar_datapath.sv
module sfar_datapath
    import sfar_pkg::*;
#(
    parameter int MAX_NEURONS = DEF_MAX_NEURONS,
    parameter int MAX_FANIN   = DEF_MAX_FANIN
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sfar_cmd_t           cmd,
    output sfar_stat_t          stat,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [NCNT_W-1:0]   cfg_data,
    input  logic [OP_W-1:0]     in_op,
    input  logic [NEURON_W-1:0] in_neuron,
    input  logic [SLOT_W-1:0]   in_slot,
    input  logic [NEURON_W-1:0] in_src,
    input  logic [CNT_W-1:0]    in_cnt,
    input  logic [ACT_W-1:0]    in_act,
    input  logic [RND_W-1:0]    in_rnd,
    input  logic                m_ready,
    output logic                m_valid,
    output logic [NEURON_W-1:0] m_neuron,
    output logic [ACT_W-1:0]    m_act
);
    localparam int NA_W   = $clog2(MAX_NEURONS);
    localparam int FA_W   = $clog2(MAX_FANIN) > 0 ? $clog2(MAX_FANIN) : 1;
    localparam int WA_W   = $clog2(MAX_NEURONS * MAX_FANIN);
    localparam int SUM_W  = ACT_W + FA_W + 1;

    logic [NCNT_W-1:0]   ncount_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [NCNT_W-1:0]   eff_n;
    logic [STRIDE_W-1:0] eff_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ncount_reg <= NCNT_W'(256);
            stride_reg <= STRIDE_W'(16);
        end else if (cfg_we) begin
            if (cfg_index == REG_NEURON_COUNT) ncount_reg <= cfg_data;
            else stride_reg <= cfg_data[STRIDE_W-1:0];
        end
    end

    always_comb begin
        if (ncount_reg == '0) eff_n = NCNT_W'(1);
        else if (32'(ncount_reg) > MAX_NEURONS) eff_n = NCNT_W'(MAX_NEURONS);
        else eff_n = ncount_reg;
        if (stride_reg == '0) eff_s = STRIDE_W'(1);
        else if (32'(stride_reg) > MAX_FANIN) eff_s = STRIDE_W'(MAX_FANIN);
        else eff_s = stride_reg;
    end

    // captured item
    logic [OP_W-1:0]     op_reg;
    logic [NEURON_W-1:0] n_reg, src_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [CNT_W-1:0]    cin_reg;
    logic [ACT_W-1:0]    act_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_op;
            n_reg <= in_neuron;
            slot_reg <= in_slot;
            src_reg <= in_src;
            cin_reg <= in_cnt;
            act_reg <= in_act;
        end
    end

    // memories
    logic [NEURON_W-1:0] wire_mem [MAX_NEURONS*MAX_FANIN];
    logic [CNT_W-1:0]    cnt_mem  [MAX_NEURONS];
    logic [ACT_W-1:0]    act_mem  [MAX_NEURONS];
    logic [NEURON_W-1:0] wire_rd;
    logic [CNT_W-1:0]    cnt_rd;
    logic [ACT_W-1:0]    act_rd;

    logic [CNT_W-1:0]    walk_reg;
    logic [CNT_W-1:0]    c_reg;       // effective count of current row
    logic [NEURON_W-1:0] from_id_reg, to_id_reg;
    logic [CNT_W-1:0]    from_slot_reg, to_slot_reg;
    logic [RND_W-1:0]    rq_reg;
    logic signed [SUM_W-1:0] acc_reg;

    logic [NEURON_W-1:0] row_n;
    logic [CNT_W-1:0]    col;
    logic [WA_W-1:0]     waddr, raddr;

    logic                div_busy;
    logic [RND_W-1:0]    div_q;
    logic [CNT_W-1:0]    div_r;

    // wiring address = row * stride + col
    always_comb begin
        row_n = from_id_reg;
        col   = div_r;
        if (cmd.wr_wire) begin
            row_n = n_reg;
            col   = CNT_W'(slot_reg);
        end else if (cmd.rd_wire) begin
            row_n = n_reg;
            // rewire reads the from slot first, then the to slot
            if (op_reg != OP_REWIRE) col = walk_reg;
            else if (cmd.wire_from) col = to_slot_reg;
            else col = from_slot_reg;
        end
        waddr = WA_W'(32'(row_n) * 32'(eff_s) + 32'(col));
        raddr = waddr;
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_wire) begin
            wire_mem[waddr] <= src_reg;
        end else if (cmd.rw_write) begin
            wire_mem[waddr] <= to_id_reg;
        end
        if (cmd.rd_wire) wire_rd <= wire_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_count) cnt_mem[n_reg[NA_W-1:0]] <= cin_reg;
        if (cmd.rd_count_n) cnt_rd <= cnt_mem[n_reg[NA_W-1:0]];
        else if (cmd.rd_count_f) cnt_rd <= cnt_mem[from_id_reg[NA_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_act) act_mem[n_reg[NA_W-1:0]] <= act_reg;
        if (cmd.rd_act) act_rd <= act_mem[wire_rd[NA_W-1:0]];
    end

    // id fetched this walk step, valid flag follows act read
    logic id_ok_reg;
    always_ff @(posedge aclk) begin
        if (cmd.rd_act) id_ok_reg <= 9'(wire_rd) < eff_n;
    end

    logic [CNT_W-1:0] c_sat;
    assign c_sat = (cnt_rd > eff_s) ? eff_s : cnt_rd;

    always_ff @(posedge aclk) begin
        if (cmd.rd_count_n || cmd.rd_count_f) c_reg <= '0;
        if (cmd.walk_clr) c_reg <= c_sat;
        if (cmd.walk_clr) walk_reg <= '0;
        else if (cmd.walk_inc) walk_reg <= walk_reg + 1'b1;
        if (cmd.acc_clr) acc_reg <= '0;
        else if (cmd.acc_add && id_ok_reg)
            acc_reg <= acc_reg + SUM_W'(signed'(act_rd));
        // rq_reg holds the random word, then each quotient in turn
        if (cmd.load) begin
            rq_reg <= in_rnd;
        end else if (cmd.set_from) begin
            from_slot_reg <= div_r;
            rq_reg <= div_q;
        end else if (cmd.set_to) begin
            to_slot_reg <= div_r;
            rq_reg <= div_q;
        end
        if (cmd.wire_from) from_id_reg <= wire_rd;
        if (cmd.wire_to) to_id_reg <= wire_rd;
    end

    // divider operand selection
    logic [RND_W-1:0] d_in;
    logic             d_neg;
    always_comb begin
        if (cmd.div_sel) begin
            d_in  = rq_reg;
            d_neg = 1'b0;
        end else begin
            d_in  = RND_W'(acc_reg);
            d_neg = acc_reg[SUM_W-1];
        end
    end

    sfar_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .neg_in    (d_neg),
        .dividend  (d_in),
        .divisor   (c_reg),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // output register
    logic                ovalid_reg;
    logic [NEURON_W-1:0] on_reg;
    logic [ACT_W-1:0]    oa_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            ovalid_reg <= 1'b1;
        end else if (m_ready) begin
            ovalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            on_reg <= n_reg;
            oa_reg <= (c_reg == '0) ? '0 : div_q[ACT_W-1:0];
        end
    end
    assign m_valid  = ovalid_reg;
    assign m_neuron = on_reg;
    assign m_act    = oa_reg;

    assign stat.op        = op_reg;
    assign stat.n_ok      = 9'(n_reg) < eff_n;
    assign stat.slot_ok   = 5'(slot_reg) < eff_s;
    assign stat.cnt_zero  = (c_sat == '0);
    assign stat.walk_done = (walk_reg == c_reg);
    assign stat.div_busy  = div_busy;
    assign stat.from_ok   = 9'(from_id_reg) < eff_n;
    assign stat.out_busy  = ovalid_reg && !m_ready;
endmodule

>>> rtl/sfar_ctrl.sv
module sfar_ctrl
    import sfar_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  sfar_stat_t stat,
    output sfar_cmd_t  cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_CNT    = 4'd2;
    localparam logic [3:0] S_WRD    = 4'd3;
    localparam logic [3:0] S_ACT    = 4'd4;
    localparam logic [3:0] S_ADD    = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_OUT    = 4'd7;
    localparam logic [3:0] S_RDIV1  = 4'd8;
    localparam logic [3:0] S_RDIV2  = 4'd9;
    localparam logic [3:0] S_RWF    = 4'd10;
    localparam logic [3:0] S_RWT    = 4'd11;
    localparam logic [3:0] S_FCNT   = 4'd12;
    localparam logic [3:0] S_FSET   = 4'd13;
    localparam logic [3:0] S_RDIV3  = 4'd14;
    localparam logic [3:0] S_RWR    = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       started_reg, started_next;

    always_comb begin
        state_next = state_reg;
        started_next = 1'b0;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                cmd.load = s_valid;
                if (s_valid) state_next = S_DEC;
            end
            S_DEC: begin
                state_next = S_IDLE;
                if (stat.n_ok) begin
                    case (stat.op)
                        OP_WR_WIRE:  cmd.wr_wire = stat.slot_ok;
                        OP_WR_COUNT: cmd.wr_count = 1'b1;
                        OP_WR_ACT:   cmd.wr_act = 1'b1;
                        OP_AVERAGE, OP_REWIRE: begin
                            cmd.rd_count_n = 1'b1;
                            state_next = S_CNT;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_CNT: begin
                cmd.walk_clr = 1'b1;
                cmd.acc_clr = 1'b1;
                if (stat.op == OP_AVERAGE) state_next = S_WRD;
                else if (stat.cnt_zero) state_next = S_IDLE;
                else state_next = S_RDIV1;
            end
            S_WRD: begin
                if (stat.walk_done) begin
                    state_next = S_DIV;
                    cmd.div_start = 1'b1;
                end else begin
                    cmd.rd_wire = 1'b1;
                    state_next = S_ACT;
                end
            end
            S_ACT: begin
                cmd.rd_act = 1'b1;
                cmd.walk_inc = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.acc_add = 1'b1;
                state_next = S_WRD;
            end
            S_DIV: begin
                if (!stat.div_busy && !stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RDIV1: begin
                // first division: from slot
                cmd.div_sel = 1'b1;
                if (!started_reg) begin
                    cmd.div_start = 1'b1;
                    started_next = 1'b1;
                end else if (!stat.div_busy) begin
                    cmd.set_from = 1'b1;
                    cmd.walk_inc = 1'b1;
                    state_next = S_RDIV2;
                end else begin
                    started_next = 1'b1;
                end
            end
            S_RDIV2: begin
                cmd.div_sel = 1'b1;
                if (!started_reg) begin
                    cmd.div_start = 1'b1;
                    started_next = 1'b1;
                end else if (!stat.div_busy) begin
                    cmd.set_to = 1'b1;
                    state_next = S_RWF;
                end else begin
                    started_next = 1'b1;
                end
            end
            S_RWF: begin
                state_next = S_RWT;
                cmd.rd_wire = 1'b1;
            end
            S_RWT: begin
                cmd.wire_from = 1'b1;
                cmd.rd_wire = 1'b1;
                state_next = S_FCNT;
            end
            S_FCNT: begin
                cmd.wire_to = 1'b1;
                cmd.rd_count_f = 1'b1;
                state_next = S_FSET;
            end
            S_FSET: begin
                cmd.walk_clr = 1'b1;
                if (!stat.from_ok || stat.cnt_zero) state_next = S_IDLE;
                else state_next = S_RDIV3;
            end
            S_RDIV3: begin
                cmd.div_sel = 1'b1;
                if (!started_reg) begin
                    cmd.div_start = 1'b1;
                    started_next = 1'b1;
                end else if (!stat.div_busy) begin
                    state_next = S_RWR;
                end else begin
                    started_next = 1'b1;
                end
            end
            S_RWR: begin
                cmd.rw_write = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            started_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            started_reg <= started_next;
        end
    end
endmodule

>>> rtl/sparse_fanin_average_rewire.sv
// Channel  | Dir | tdata fields (low bit up)                              | tuser
// s_axis   | in  | operation, neuron, slot, source_neuron, fanin_count,    | -
//          |     | activation, random_word (76 bits, padded to 80)        |
// m_axis   | out | result_neuron, new_activation (24 bits)                | -
// cfg      | in  | 0 neuron_count, 1 row_stride                           | -
// Write and ignored items return to idle from the decode state. An average walks each
// live slot (wiring read, activation read, accumulate), then runs a bit-serial divide;
// a rewire takes three divides of the random word. No new item is taken until one is done.
// aresetn is synchronous; memories are not cleared. A stalled result holds
// in the output register; the next average waits only if it is still held.
module sparse_fanin_average_rewire
    import sfar_pkg::*;
#(
    parameter int MAX_NEURONS = DEF_MAX_NEURONS,
    parameter int MAX_FANIN   = DEF_MAX_FANIN
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [NCNT_W-1:0]   cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [79:0]         s_axis_tdata,  // op, neuron, slot, src, cnt, act, rnd
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata   // result_neuron, new_activation
);
    sfar_cmd_t  cmd;
    sfar_stat_t stat;
    logic [NEURON_W-1:0] rn;
    logic [ACT_W-1:0]    ra;

    sfar_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sfar_datapath #(
        .MAX_NEURONS (MAX_NEURONS),
        .MAX_FANIN   (MAX_FANIN)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_axis_tdata[2:0]),
        .in_neuron (s_axis_tdata[10:3]),
        .in_slot   (s_axis_tdata[14:11]),
        .in_src    (s_axis_tdata[22:15]),
        .in_cnt    (s_axis_tdata[27:23]),
        .in_act    (s_axis_tdata[43:28]),
        .in_rnd    (s_axis_tdata[75:44]),
        .m_ready   (m_axis_tready),
        .m_valid   (m_axis_tvalid),
        .m_neuron  (rn),
        .m_act     (ra)
    );

    assign m_axis_tdata = {ra, rn};
endmodule

>>> tb/sparse_fanin_average_rewire_tb.sv
`timescale 1ns / 100ps

module sparse_fanin_average_rewire_tb;
    import sfar_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE_CYC   = 150;
    localparam int PHASE_ITEMS  = 230;
    localparam int N_PHASES     = 8;

    typedef struct packed {
        logic [RND_W-1:0]    rnd;
        logic [ACT_W-1:0]    act;
        logic [CNT_W-1:0]    cnt;
        logic [NEURON_W-1:0] src;
        logic [SLOT_W-1:0]   slot;
        logic [NEURON_W-1:0] neuron;
        logic [OP_W-1:0]     op;
    } sfar_item_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = REG_NEURON_COUNT;
    logic [NCNT_W-1:0]  cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [79:0]        s_axis_tdata = '0;  // op, neuron, slot, src, cnt, act, rnd
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [23:0]        m_axis_tdata;       // result_neuron, new_activation

    int errors = 0;
    int idle_cyc = 0;
    bit no_idle = 0;

    sparse_fanin_average_rewire dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Network mirror: tracks contents plus which entries have been written.
    class fanin_scoreboard;
        bit [7:0]     wire_t[4096];
        bit           wire_ok[4096];
        bit [4:0]     cnt_t[256];
        bit           cnt_ok[256];
        bit [15:0]    act_t[256];
        bit           act_ok[256];
        int unsigned  nn = 256;
        int unsigned  stride = 16;
        bit [23:0]    mean_q[$];

        function void set_reg(logic idx, logic [NCNT_W-1:0] val);
            if (idx == REG_NEURON_COUNT)
                nn = (val < 1) ? 1 : (val > 256) ? 256 : val;
            else
                stride = (val[4:0] < 1) ? 1 : (val[4:0] > 16) ? 16 : val[4:0];
        endfunction

        function int unsigned live(int unsigned n);
            return (cnt_t[n] > stride) ? stride : cnt_t[n];
        endfunction

        // Never let the block read an entry that was never written.
        function bit readable(sfar_item_t it);
            int unsigned c, a, id, bits, f, t;
            if (it.neuron >= nn) return 1;
            if (it.op == OP_AVERAGE) begin
                if (!cnt_ok[it.neuron]) return 0;
                c = live(it.neuron);
                for (int unsigned j = 0; j < c; j++) begin
                    a = it.neuron * stride + j;
                    if (!wire_ok[a]) return 0;
                    id = wire_t[a];
                    if (id < nn && !act_ok[id]) return 0;
                end
            end else if (it.op == OP_REWIRE) begin
                if (!cnt_ok[it.neuron]) return 0;
                c = live(it.neuron);
                if (c == 0) return 1;
                bits = it.rnd;
                f = bits % c;
                bits = bits / c;
                t = bits % c;
                if (!wire_ok[it.neuron * stride + f] || !wire_ok[it.neuron * stride + t])
                    return 0;
                id = wire_t[it.neuron * stride + f];
                if (id < nn && !cnt_ok[id]) return 0;
            end
            return 1;
        endfunction

        function void note_beat(sfar_item_t it);
            int unsigned c, m, bits, f, t, fid, tid, id;
            int sum, mean;
            if (it.neuron >= nn) return;
            case (it.op)
                OP_WR_WIRE: begin
                    if (it.slot < stride) begin
                        wire_t[it.neuron * stride + it.slot] = it.src;
                        wire_ok[it.neuron * stride + it.slot] = 1;
                    end
                end
                OP_WR_COUNT: begin
                    cnt_t[it.neuron] = it.cnt;
                    cnt_ok[it.neuron] = 1;
                end
                OP_WR_ACT: begin
                    act_t[it.neuron] = it.act;
                    act_ok[it.neuron] = 1;
                end
                OP_AVERAGE: begin
                    c = live(it.neuron);
                    sum = 0;
                    mean = 0;
                    for (int unsigned j = 0; j < c; j++) begin
                        id = wire_t[it.neuron * stride + j];
                        if (id < nn) sum += $signed(act_t[id]);
                    end
                    if (c > 0) mean = sum / int'(c);
                    mean_q.push_back({mean[15:0], it.neuron});
                end
                OP_REWIRE: begin
                    c = live(it.neuron);
                    if (c != 0) begin
                        bits = it.rnd;
                        f = bits % c;
                        bits = bits / c;
                        t = bits % c;
                        bits = bits / c;
                        fid = wire_t[it.neuron * stride + f];
                        tid = wire_t[it.neuron * stride + t];
                        if (fid < nn) begin
                            m = live(fid);
                            if (m != 0) begin
                                wire_t[fid * stride + bits % m] = 8'(tid);
                                wire_ok[fid * stride + bits % m] = 1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function string check_result(logic [23:0] d);
            bit [23:0] e;
            string s;
            if (mean_q.size() == 0) return $sformatf("unexpected result %h", d);
            e = mean_q.pop_front();
            s = "";
            if (d[7:0] !== e[7:0])
                s = $sformatf("result_neuron %0d, expected %0d", d[7:0], e[7:0]);
            if (d[23:8] !== e[23:8])
                s = {s, $sformatf(" new_activation %0d, expected %0d (neuron %0d)",
                     $signed(d[23:8]), $signed(e[23:8]), e[7:0])};
            return s;
        endfunction
    endclass

    fanin_scoreboard sb = new();
    sfar_item_t pend_q[$];

    function automatic sfar_item_t mk(int op, int n, int sl, int src, int cnt,
                                      int act, logic [31:0] rnd);
        sfar_item_t it;
        it.op = OP_W'(op); it.neuron = NEURON_W'(n); it.slot = SLOT_W'(sl);
        it.src = NEURON_W'(src); it.cnt = CNT_W'(cnt); it.act = ACT_W'(act);
        it.rnd = rnd;
        return it;
    endfunction

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 15);
    endfunction

    task automatic send(sfar_item_t it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, it.rnd, it.act, it.cnt, it.src, it.slot, it.neuron, it.op};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_beat(it);
    endtask

    task automatic drain_and_settle();
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        while (sb.mean_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [NCNT_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // Fill a neuron's row and its feeders' activations so the average reads
    // only written entries.
    task automatic queue_build(int n, int win);
        int c, s;
        c = $urandom_range(1, sb.stride);
        pend_q.push_back(mk(OP_WR_COUNT, n, $urandom, $urandom, c, $urandom, $urandom));
        for (int j = 0; j < c; j++) begin
            s = $urandom_range(0, win - 1);
            pend_q.push_back(mk(OP_WR_WIRE, n, j, s, $urandom, $urandom, $urandom));
            pend_q.push_back(mk(OP_WR_ACT, s, $urandom, $urandom, $urandom, $urandom,
                                $urandom));
        end
        pend_q.push_back(mk(OP_WR_ACT, n, $urandom, $urandom, $urandom, $urandom, $urandom));
        pend_q.push_back(mk(OP_AVERAGE, n, $urandom, $urandom, $urandom, $urandom, $urandom));
    endtask

    function automatic sfar_item_t rand_item(int win);
        sfar_item_t it;
        int r;
        for (int k = 0; k < 30; k++) begin
            it = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            r = $urandom_range(0, 99);
            it.op = (r < 18) ? OP_WR_WIRE : (r < 28) ? OP_WR_COUNT : (r < 40) ? OP_WR_ACT :
                    (r < 68) ? OP_AVERAGE : (r < 92) ? OP_REWIRE :
                    OP_W'($urandom_range(5, 7));
            if ($urandom_range(0, 19) != 0) it.neuron = NEURON_W'($urandom_range(0, win - 1));
            if ($urandom_range(0, 6) != 0) it.src = NEURON_W'($urandom_range(0, win - 1));
            if ($urandom_range(0, 3) != 0) it.cnt = CNT_W'($urandom_range(0, 4));
            if ($urandom_range(0, 2) != 0) it.slot = SLOT_W'($urandom_range(0, 4));
            if (sb.readable(it)) return it;
        end
        return mk(OP_WR_WIRE, $urandom_range(0, win - 1), $urandom_range(0, 4),
                  $urandom_range(0, win - 1), $urandom, $urandom, $urandom);
    endfunction

    // receiver with random stalls
    initial begin
        string s;
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            s = sb.check_result(m_axis_tdata);
            if (s != "") report(s);
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cyc);
            $display("** sparse_fanin_average_rewire: FAILED **");
            $finish;
        end
    end

    int unsigned ph_nn[N_PHASES]     = '{256, 1, 3, 24, 0, 511, 200, 256};
    int unsigned ph_stride[N_PHASES] = '{16, 1, 4, 5, 0, 31, 16, 1};

    initial begin
        int win;
        sfar_item_t it;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, every operation, zero count, unknown code
        send(mk(OP_WR_ACT, 0, 0, 0, 0, 32767, 0));
        send(mk(OP_WR_ACT, 255, 15, 255, 31, -32768, 32'hffff_ffff));
        send(mk(OP_WR_ACT, 1, 0, 0, 0, -1, 0));
        send(mk(OP_WR_COUNT, 5, 0, 0, 3, 0, 0));
        send(mk(OP_WR_WIRE, 5, 0, 0, 0, 0, 0));
        send(mk(OP_WR_WIRE, 5, 1, 255, 0, 0, 0));
        send(mk(OP_WR_WIRE, 5, 2, 1, 0, 0, 0));
        send(mk(OP_AVERAGE, 5, 0, 0, 0, 0, 0));
        send(mk(OP_WR_COUNT, 0, 0, 0, 1, 0, 0));
        send(mk(OP_WR_WIRE, 0, 0, 5, 0, 0, 0));
        send(mk(OP_WR_COUNT, 1, 0, 0, 2, 0, 0));
        send(mk(OP_WR_WIRE, 1, 0, 255, 0, 0, 0));
        send(mk(OP_WR_WIRE, 1, 1, 255, 0, 0, 0));
        send(mk(OP_WR_ACT, 5, 0, 0, 0, 4096, 0));
        send(mk(OP_AVERAGE, 1, 0, 0, 0, 0, 0));
        send(mk(OP_WR_COUNT, 255, 15, 255, 0, 0, 0));
        send(mk(OP_REWIRE, 5, 0, 0, 0, 0, 32'hffff_ffff));
        send(mk(OP_REWIRE, 5, 0, 0, 0, 0, 32'h0000_0007));
        send(mk(OP_AVERAGE, 5, 0, 0, 0, 0, 0));
        send(mk(OP_AVERAGE, 255, 0, 0, 0, 0, 0));
        send(mk(OP_REWIRE, 255, 0, 0, 0, 0, 32'h1234_5678));
        send(mk(OP_WR_WIRE, 255, 15, 255, 0, 0, 0));
        send(mk(3'd7, 255, 15, 255, 31, -1, 32'hffff_ffff));
        send(mk(3'd5, 0, 0, 0, 0, 0, 0));

        for (int p = 0; p < N_PHASES; p++) begin
            drain_and_settle();
            write_reg(REG_NEURON_COUNT, NCNT_W'(ph_nn[p]));
            write_reg(REG_ROW_STRIDE, NCNT_W'(ph_stride[p]));
            no_idle = (p % 3 == 2);
            win = (sb.nn < 20) ? sb.nn : 20;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2) begin
                    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
                    while (sb.mean_q.size() != 0) @(posedge aclk);
                    @(posedge aclk);
                end
                if (pend_q.size() == 0 && $urandom_range(0, 9) == 0)
                    queue_build($urandom_range(0, win - 1), win);
                if (pend_q.size() != 0) it = pend_q.pop_front();
                else it = rand_item(win);
                send(it);
            end
        end

        drain_and_settle();
        if (errors == 0)
            $display("** sparse_fanin_average_rewire: PASSED **");
        else
            $display("** sparse_fanin_average_rewire: FAILED **");
        $finish;
    end

endmodule
